### rtl/npd_pkg.sv
// shared types and constants of the name-value pair deframer
package npd_pkg;

	// byte kinds on the result channel
	localparam logic [1:0] KIND_LEN   = 2'd0;
	localparam logic [1:0] KIND_KEY   = 2'd1;
	localparam logic [1:0] KIND_VALUE = 2'd2;

	// parse phases
	localparam logic [1:0] PH_KEY_LEN = 2'd0;
	localparam logic [1:0] PH_VAL_LEN = 2'd1;
	localparam logic [1:0] PH_MSG     = 2'd2;

	// key bytes are kept only below index KEY_LIMIT - 1
	localparam int KEY_LIMIT = 256;

	localparam logic [16:0] CAPACITY_RESET = 17'd4096;

	// classified item handed from the front to the back
	typedef struct packed {
		logic [7:0]  data;
		logic [1:0]  kind;
		logic [32:0] idx;
		logic        pair_end;
		logic [30:0] key_len;
		logic [30:0] value_len;
	} npd_item_t;

endpackage

### rtl/name_value_pair_deframer_top.sv
// top level of the name-value pair deframer
//
// deframes a name-value parameter stream one byte per item: each pair is a key
// length, a value length (one byte with the top bit clear, or four big-endian
// bytes with the top bit masked), then the key bytes and the value bytes. every
// accepted byte yields exactly one result item that echoes the byte with its
// kind (length, key or value), a keep flag, a pair-end mark and the decoded
// lengths of the current pair. key bytes are kept below message index 255,
// all message bytes below capacity minus one. one item is taken per clock
// while the queue has room; the rate is set by the parse step in the front
// end, which needs one 33-bit position increment and compare per byte. the
// front writes each accepted item into the queue, and the back moves it on into
// the output register. the front and the back are parted by a QUEUE_DEPTH-entry
// queue, so in_stall rises only when that queue is full. the user must write
// capacity through cfg_we/cfg_wdata only while no item is in flight; the block
// itself does not enforce this. capacity resets to 4096
module name_value_pair_deframer_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: message capacity
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  byte_out,
	output logic [1:0]  kind,
	output logic        kept,
	output logic        pair_end,
	output logic [30:0] key_len,
	output logic [30:0] value_len
);
	import npd_pkg::*;

	logic [16:0] capacity_q;
	logic        in_acc;
	logic        q_full;
	logic        q_empty;
	logic        q_pop;
	npd_item_t   front_item;
	npd_item_t   q_head;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// the front only waits for room in the queue
	assign in_stall = q_full;
	assign in_acc   = in_valid && !q_full;

	npd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (in_acc),
		.data_byte (data_byte),
		.item      (front_item)
	);

	npd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_acc),
		.push_item (front_item),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	// back end drains the queue whenever the output register is free or being taken
	npd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.capacity  (capacity_q),
		.head      (q_head),
		.empty     (q_empty),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.byte_out  (byte_out),
		.kind      (kind),
		.kept      (kept),
		.pair_end  (pair_end),
		.key_len   (key_len),
		.value_len (value_len)
	);

endmodule

### rtl/npd_front.sv
// front end: accepts stream bytes, tracks the pair framing and classifies each byte
module npd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  logic [7:0]        data_byte,
	output npd_pkg::npd_item_t item
);
	import npd_pkg::*;

	logic [1:0]  phase_q;
	logic [32:0] pos_q;
	logic [23:0] lenb_q;
	logic [30:0] klen_q;
	logic [30:0] vlen_q;

	logic        in_len;
	logic        done;
	logic [30:0] len;
	logic [23:0] lenb_new;
	logic [30:0] klen_upd;
	logic [30:0] vlen_upd;
	logic [32:0] pos_inc;
	logic [32:0] total;
	logic        pair_end;

	assign in_len  = ~phase_q[1];
	assign pos_inc = pos_q + 33'd1;
	assign total   = {2'b00, klen_q} + {2'b00, vlen_q};

	always_comb begin
		case (pos_q[1:0])
			2'd0:    lenb_new = lenb_q | {data_byte, 16'h0000};
			2'd1:    lenb_new = lenb_q | {8'h00, data_byte, 8'h00};
			2'd2:    lenb_new = lenb_q | {16'h0000, data_byte};
			default: lenb_new = lenb_q;
		endcase
	end

	// short form on the first byte, long form completes on the fourth
	assign done = in_len && (((pos_q == 33'd0) && !data_byte[7]) ||
		((pos_q == 33'd3) && lenb_q[23]));
	assign len  = (pos_q == 33'd0) ? {23'd0, data_byte} : {lenb_q[22:0], data_byte};

	always_comb begin
		klen_upd = klen_q;
		vlen_upd = vlen_q;
		if (done) begin
			if (phase_q == PH_VAL_LEN) begin
				vlen_upd = len;
			end else begin
				klen_upd = len;
			end
		end
	end

	always_comb begin
		if (in_len) begin
			// empty pair ends on its last length byte
			pair_end = done && (phase_q == PH_VAL_LEN) && (klen_q == 31'd0) && (len == 31'd0);
		end else begin
			pair_end = pos_inc >= total;
		end
	end

	always_comb begin
		item.data      = data_byte;
		item.idx       = pos_q;
		item.pair_end  = pair_end;
		item.key_len   = klen_upd;
		item.value_len = vlen_upd;
		if (in_len) begin
			item.kind = KIND_LEN;
		end else if (pos_q < {2'b00, klen_q}) begin
			item.kind = KIND_KEY;
		end else begin
			item.kind = KIND_VALUE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_KEY_LEN;
			pos_q   <= '0;
			lenb_q  <= '0;
			klen_q  <= '0;
			vlen_q  <= '0;
		end else if (acc) begin
			if (pair_end) begin
				phase_q <= PH_KEY_LEN;
				pos_q   <= '0;
				lenb_q  <= '0;
				klen_q  <= '0;
				vlen_q  <= '0;
			end else if (in_len) begin
				klen_q <= klen_upd;
				vlen_q <= vlen_upd;
				if (done) begin
					phase_q <= phase_q + 2'd1;
					pos_q   <= '0;
					lenb_q  <= '0;
				end else begin
					pos_q  <= pos_inc;
					lenb_q <= lenb_new;
				end
			end else begin
				pos_q <= pos_inc;
			end
		end
	end

endmodule

### rtl/npd_queue.sv
// small register queue between the front and the back
module npd_queue #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  npd_pkg::npd_item_t push_item,
	input  logic               pop,
	output npd_pkg::npd_item_t head,
	output logic               full,
	output logic               empty
);
	import npd_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	npd_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/npd_back.sv
// back end: applies the keep limits and holds the result register
module npd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [16:0]        capacity,
	input  npd_pkg::npd_item_t head,
	input  logic               empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         byte_out,
	output logic [1:0]         kind,
	output logic               kept,
	output logic               pair_end,
	output logic [30:0]        key_len,
	output logic [30:0]        value_len
);
	import npd_pkg::*;

	logic        out_valid_q;
	logic [16:0] msg_limit;
	logic        below_msg;
	logic        below_key;
	logic        keep;

	assign msg_limit = (capacity == 17'd0) ? 17'd0 : capacity - 17'd1;
	assign below_msg = head.idx < {16'd0, msg_limit};
	assign below_key = head.idx < 33'(KEY_LIMIT - 1);

	always_comb begin
		case (head.kind)
			KIND_KEY:   keep = below_key && below_msg;
			KIND_VALUE: keep = below_msg;
			default:    keep = 1'b0;
		endcase
	end

	assign pop       = !empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			byte_out  <= head.data;
			kind      <= head.kind;
			kept      <= keep;
			pair_end  <= head.pair_end;
			key_len   <= head.key_len;
			value_len <= head.value_len;
		end
	end

endmodule

### verif/name_value_pair_deframer_top_test.sv
// self-checking testbench of the name-value pair deframer, predicting every result item
module name_value_pair_deframer_top_test;
	import npd_pkg::*;

	// one expected result item, field for field as on the result channel
	typedef struct packed {
		logic [7:0]  data;
		logic [1:0]  kind;
		logic        kept;
		logic        pair_end;
		logic [30:0] key_len;
		logic [30:0] value_len;
	} param_byte_t;

	// block ports, every input known from time zero
	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [16:0] cfg_wdata = '0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  byte_out;
	logic [1:0]  kind;
	logic        kept;
	logic        pair_end;
	logic [30:0] key_len;
	logic [30:0] value_len;

	// shadow of the parser state and of the capacity register
	logic [16:0] cap_shadow    = CAPACITY_RESET;
	logic [1:0]  parse_phase   = PH_KEY_LEN;
	logic [32:0] phase_pos     = '0;
	logic [23:0] len_prefix    = '0;
	logic [30:0] cur_key_len   = '0;
	logic [30:0] cur_value_len = '0;

	// expected result items, oldest first
	param_byte_t pending_results[$];

	// run bookkeeping
	int fail_count   = 0;
	int items_sent   = 0;
	int pairs_seen   = 0;
	int kept_seen    = 0;
	int stall_cycles = 0;

	// idling knobs, and the long receiver hold-off handshake
	bit tx_idle_on    = 1'b1;
	bit rx_idle_on    = 1'b1;
	int hold_requests = 0;
	int hold_served   = 0;
	int hold_left     = 0;

	localparam int HOLD_CYCLES = 200;

	name_value_pair_deframer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.byte_out  (byte_out),
		.kind      (kind),
		.kept      (kept),
		.pair_end  (pair_end),
		.key_len   (key_len),
		.value_len (value_len)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

	// advance the shadow parser by one stream byte and return the item it yields
	function automatic param_byte_t deframe_byte(input logic [7:0] b);
		param_byte_t r;
		logic [32:0] msg_limit;
		logic [32:0] pair_total;
		logic        len_done;
		logic [30:0] len_val;
		r         = '0;
		r.data    = b;
		r.kind    = KIND_LEN;
		len_done  = 1'b0;
		len_val   = '0;
		// capacity 0 keeps nothing, like capacity 1
		msg_limit = (cap_shadow != 0) ? {16'd0, cap_shadow} - 33'd1 : '0;
		if (parse_phase == PH_KEY_LEN || parse_phase == PH_VAL_LEN) begin
			// the first three bytes of a long length are collected big-endian
			case (phase_pos)
				33'd0: len_prefix[23:16] = b;
				33'd1: len_prefix[15:8]  = b;
				33'd2: len_prefix[7:0]   = b;
				default: ;
			endcase
			phase_pos = phase_pos + 33'd1;
			if (phase_pos == 33'd1 && !b[7]) begin
				len_done = 1'b1;
				len_val  = {23'd0, b};
			end else if (phase_pos == 33'd4 && len_prefix[23]) begin
				// top bit of the first byte is the long flag, masked off here
				len_done = 1'b1;
				len_val  = {len_prefix[22:0], b};
			end
			if (len_done) begin
				if (parse_phase == PH_VAL_LEN)
					cur_value_len = len_val;
				else
					cur_key_len = len_val;
				parse_phase = parse_phase + 2'd1;
				phase_pos   = '0;
				len_prefix  = '0;
			end
		end else begin
			// message bytes: key first, then value, one shared index
			if (phase_pos < {2'd0, cur_key_len}) begin
				r.kind = KIND_KEY;
				r.kept = (phase_pos < 33'(KEY_LIMIT - 1)) && (phase_pos < msg_limit);
			end else begin
				r.kind = KIND_VALUE;
				r.kept = phase_pos < msg_limit;
			end
			phase_pos = phase_pos + 33'd1;
		end
		r.key_len   = cur_key_len;
		r.value_len = cur_value_len;
		// a zero-length pair closes on its last length byte
		pair_total = {2'd0, cur_key_len} + {2'd0, cur_value_len};
		if (parse_phase >= PH_MSG && phase_pos >= pair_total) begin
			r.pair_end    = 1'b1;
			parse_phase   = PH_KEY_LEN;
			phase_pos     = '0;
			len_prefix    = '0;
			cur_key_len   = '0;
			cur_value_len = '0;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [30:0] want,
			input logic [30:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	// compare every accepted result item against the oldest expectation
	always @(posedge clk) begin : check_results
		param_byte_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result item with none expected: byte_out %0h", byte_out);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("byte_out", 31'(want.data), 31'(byte_out));
				check_field("kind", 31'(want.kind), 31'(kind));
				check_field("kept", 31'(want.kept), 31'(kept));
				check_field("pair_end", 31'(want.pair_end), 31'(pair_end));
				check_field("key_len", want.key_len, key_len);
				check_field("value_len", want.value_len, value_len);
				if (pair_end === 1'b1)
					pairs_seen++;
				if (kept === 1'b1)
					kept_seen++;
			end
		end
	end

	// receiver: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left   = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= rx_idle_on && ($urandom_range(99) < 31);
		end
	end

	// offer one stream byte, optionally after a random gap, until it is taken
	task automatic send_byte(input logic [7:0] b);
		while (tx_idle_on && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (in_stall) begin
			stall_cycles++;
			@(posedge clk);
		end
		pending_results.push_back(deframe_byte(b));
		items_sent++;
	endtask

	// drop valid and let every expected item come out
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// capacity is only written with nothing in flight
	task automatic write_capacity(input logic [16:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we     <= 1'b0;
		cap_shadow = value;
	endtask

	// a length in short form when it fits and the long form is not asked for, else in four-byte form
	task automatic send_length(input logic [30:0] len, input bit long_form);
		if (!long_form && len < 31'd128) begin
			send_byte(len[7:0]);
		end else begin
			send_byte({1'b1, len[30:24]});
			send_byte(len[23:16]);
			send_byte(len[15:8]);
			send_byte(len[7:0]);
		end
	endtask

	task automatic send_pair(input int key_n, input int value_n, input bit key_long,
			input bit value_long);
		send_length(31'(key_n), key_long);
		send_length(31'(value_n), value_long);
		repeat (key_n + value_n)
			send_byte(8'($urandom_range(255)));
	endtask

	// well-formed pair with random content; mostly short, sometimes empty or long
	task automatic send_random_pair();
		int key_n;
		int value_n;
		int roll;
		key_n   = $urandom_range(12);
		value_n = $urandom_range(24);
		roll    = $urandom_range(19);
		if (roll < 2) begin
			key_n   = 0;
			value_n = 0;
		end else if (roll == 2) begin
			value_n = $urandom_range(200);
		end else if (roll == 3) begin
			key_n = $urandom_range(160);
		end
		send_pair(key_n, value_n, $urandom_range(4) == 0, $urandom_range(4) == 0);
	endtask

	task automatic run_random_pairs(input int count);
		int stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at)
			send_random_pair();
	endtask

	// hand-picked stream: empty pairs in both forms, byte extremes, key-only pair
	task automatic test_directed();
		logic [7:0] seq[$];
		seq = '{8'h00, 8'h00,
			8'h80, 8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00,
			8'h01, 8'h01, 8'hFF, 8'h00,
			8'h80, 8'h00, 8'h00, 8'h01, 8'h00, 8'hA5,
			8'h00, 8'h02, 8'h7F, 8'h80};
		foreach (seq[i])
			send_byte(seq[i]);
		wait_idle();
	endtask

	// reset capacity, random gaps on both sides
	task automatic test_random_stream();
		run_random_pairs(60);
		wait_idle();
	endtask

	// a long stretch with no idling anywhere
	task automatic test_steady_stream();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		run_random_pairs(80);
		wait_idle();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// receiver holds off while the sender keeps offering, so the block backs up
	task automatic test_output_hold();
		hold_requests++;
		run_random_pairs(40);
		wait_idle();
	endtask

	// key bytes past index 254 drop even with plenty of capacity
	task automatic test_key_limit();
		write_capacity(17'd65536);
		send_pair(258, 3, 1'b1, 1'b0);
		write_capacity(17'h1FFFF);
		run_random_pairs(20);
		wait_idle();
	endtask

	// smallest documented capacity: value bytes from index 255 on are dropped
	task automatic test_capacity_limit();
		write_capacity(17'd256);
		send_pair(4, 255, 1'b0, 1'b1);
		wait_idle();
	endtask

	// capacities below the documented range keep nothing or almost nothing
	task automatic test_tiny_capacity();
		write_capacity(17'd0);
		run_random_pairs(20);
		write_capacity(17'd1);
		run_random_pairs(20);
		write_capacity(17'd2);
		run_random_pairs(20);
		write_capacity(CAPACITY_RESET);
		run_random_pairs(20);
		wait_idle();
	endtask

	// widest lengths; the pair is left open, so this runs last
	task automatic test_huge_lengths();
		logic [31:0] r;
		r = $urandom();
		send_length(31'h7FFFFFFF, 1'b1);
		send_length({7'h7F, r[23:0]}, 1'b1);
		repeat (12)
			send_byte(8'($urandom_range(255)));
		wait_idle();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_stream();
		test_steady_stream();
		test_output_hold();
		test_key_limit();
		test_capacity_limit();
		test_tiny_capacity();
		test_huge_lengths();
		$display("%0d bytes parsed into %0d closed pairs, %0d bytes kept",
			items_sent, pairs_seen, kept_seen);
		$display("input stalled %0d cycles; capacities 0, 1, 2, 256, 4096, 65536, 131071",
			stall_cycles);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
